// ===== sv/pdtl_pkg.sv =====
// Shared types and constants for the three-axis PD torque limiter.
`timescale 1ns / 1ps

package pdtl_pkg;

    localparam int AXES      = 3;
    localparam int ANGLE_W   = 23;
    localparam int ERR_W     = 24;
    localparam int FORCE_W   = 20;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TMAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TMIN = 2'd3;

    localparam logic [CFG_W-1:0] KP_RESET   = 32'd26214;
    localparam logic [CFG_W-1:0] KD_RESET   = 32'd6554;
    localparam logic [CFG_W-1:0] TMAX_RESET = 32'h0002_0000;
    localparam logic [CFG_W-1:0] TMIN_RESET = 32'hFFFE_0000;

    // 30.0 in Q16.16, and the force scales with and without limiting.
    localparam logic [31:0] LIMIT_Q16   = 32'd1966080;
    localparam logic [32:0] FORCE_SCALE = 33'd10000;
    localparam logic [32:0] LIMIT_FORCE = 33'd300000;

    // Divider: |t| * 300000 over the largest |t|, quotient below 2^19.
    localparam int DIV_Q_W   = 19;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W - 1;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] numer;
        logic [DIV_DEN_W-1:0] denom;
    } pdtl_div_req_t;

endpackage

// ===== sv/pdtl_div.sv =====
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps

module pdtl_div
    import pdtl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pdtl_div_req_t      req,
    output logic               done,
    output logic [DIV_Q_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] dvs_reg;
    logic [DIV_Q_W-1:0]   q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The divisor starts aligned to the top quotient bit and walks down.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.numer;
            dvs_reg <= {req.denom, {(DIV_Q_W-1){1'b0}}};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_reg <= rem_reg - dvs_reg;
                q_reg   <= {q_reg[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[DIV_Q_W-2:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== sv/three_axis_pd_torque_limiter.sv =====
// Three-axis PD controller with torque clamp and proportional torque limit.
// Sequence: per-axis D products, derivative fix-up, per-axis P products and clamp, largest
// magnitude scan, per-axis force products and, with limiting, a divide on each axis, then output.
// One transaction at a time: in_ready is high only in idle, and a single shared 33x33
// multiplier and a bit-serial divider step through the three axes.
// Reset: rst_n clears the error and derivative history, loads the default gains and bounds.
`timescale 1ns / 1ps

module three_axis_pd_torque_limiter
    import pdtl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [ANGLE_W-1:0]  desired_angle_0,
    input  logic signed [ANGLE_W-1:0]  desired_angle_1,
    input  logic signed [ANGLE_W-1:0]  desired_angle_2,
    input  logic signed [ANGLE_W-1:0]  measured_angle_0,
    input  logic signed [ANGLE_W-1:0]  measured_angle_1,
    input  logic signed [ANGLE_W-1:0]  measured_angle_2,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [FORCE_W-1:0]  force_command_0,
    output logic signed [FORCE_W-1:0]  force_command_1,
    output logic signed [FORCE_W-1:0]  force_command_2,
    output logic                       torque_limited,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DMUL  = 4'd1;
    localparam logic [3:0] S_DWB   = 4'd2;
    localparam logic [3:0] S_DFIX  = 4'd3;
    localparam logic [3:0] S_PMUL  = 4'd4;
    localparam logic [3:0] S_PWB   = 4'd5;
    localparam logic [3:0] S_LARGE = 4'd6;
    localparam logic [3:0] S_FMUL  = 4'd7;
    localparam logic [3:0] S_FWB   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       load_out;

    logic [31:0] kp_reg;
    logic [31:0] kd_reg;
    logic signed [31:0] tmax_reg;
    logic signed [31:0] tmin_reg;

    logic signed [ERR_W-1:0] prev_err_reg [AXES];
    logic signed [31:0]      prev_d_reg   [AXES];
    logic signed [ERR_W-1:0] err_reg      [AXES];
    logic signed [31:0]      d_reg        [AXES];
    logic signed [31:0]      t_reg        [AXES];
    logic [31:0]             mag_reg      [AXES];
    logic signed [FORCE_W-1:0] force_reg  [AXES];
    logic [31:0]             largest_reg;
    logic signed [65:0]      prod_reg;

    logic signed [FORCE_W-1:0] out_force_reg [AXES];
    logic                      out_limited_reg;
    logic                      out_valid_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [ERR_W:0] diff;
    logic signed [45:0] prod_q16;
    logic signed [31:0] d_sat;
    logic signed [46:0] sum;
    logic signed [46:0] tmax_ext;
    logic signed [46:0] tmin_ext;
    logic signed [31:0] t_clamp;
    logic [31:0]        mag;
    logic               limited;
    logic               all_zero;
    logic               all_nonzero;
    logic signed [31:0] d_used [AXES];
    logic [DIV_Q_W-1:0] scaled_q;
    logic signed [FORCE_W-1:0] force_scaled;
    logic signed [FORCE_W-1:0] force_div;

    pdtl_div_req_t      div_req;
    logic               div_done;
    logic [DIV_Q_W-1:0] div_q;

    pdtl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign limited = largest_reg > LIMIT_Q16;

    // Derivative replacement and history update decisions.
    always_comb
    begin
        all_zero    = 1'b1;
        all_nonzero = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            if (d_reg[i] != '0)
            begin
                all_zero = 1'b0;
            end
        end
        for (int i = 0; i < AXES; i++)
        begin
            d_used[i] = all_zero ? prev_d_reg[i] : d_reg[i];
            if (d_used[i] == '0)
            begin
                all_nonzero = 1'b0;
            end
        end
    end

    // Shared multiplier operand selection.
    assign diff = {err_reg[axis_reg][ERR_W-1], err_reg[axis_reg]}
                - {prev_err_reg[axis_reg][ERR_W-1], prev_err_reg[axis_reg]};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DMUL:
            begin
                mul_a = {{(33-ERR_W-1){diff[ERR_W]}}, diff};
                mul_b = {1'b0, kd_reg};
            end
            S_PMUL:
            begin
                mul_a = {{(33-ERR_W){err_reg[axis_reg][ERR_W-1]}}, err_reg[axis_reg]};
                mul_b = {1'b0, kp_reg};
            end
            S_FMUL:
            begin
                mul_a = {1'b0, mag_reg[axis_reg]};
                mul_b = limited ? LIMIT_FORCE : FORCE_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product floor-shifted back to Q16.16.
    assign prod_q16 = prod_reg[65:20];

    always_comb
    begin
        if (!prod_q16[45] && (|prod_q16[44:31]))
        begin
            d_sat = 32'sh7FFF_FFFF;
        end
        else if (prod_q16[45] && !(&prod_q16[44:31]))
        begin
            d_sat = 32'sh8000_0000;
        end
        else
        begin
            d_sat = prod_q16[31:0];
        end
    end

    // Torque sum and clamp; the lower bound wins when the bounds cross.
    assign sum      = {prod_q16[45], prod_q16} + {{15{d_reg[axis_reg][31]}}, d_reg[axis_reg]};
    assign tmax_ext = {{15{tmax_reg[31]}}, tmax_reg};
    assign tmin_ext = {{15{tmin_reg[31]}}, tmin_reg};

    always_comb
    begin
        priority if (tmin_ext > sum || tmin_ext > tmax_ext && sum > tmax_ext)
        begin
            t_clamp = tmin_reg;
        end
        else if (sum > tmax_ext)
        begin
            t_clamp = tmax_reg;
        end
        else
        begin
            t_clamp = sum[31:0];
        end
    end

    assign mag = t_reg[axis_reg][31] ? (~t_reg[axis_reg] + 32'd1) : t_reg[axis_reg];

    // The command is the negated torque, so a negative torque gives a positive force.
    assign scaled_q     = prod_reg[DIV_Q_W+15:16];
    assign force_scaled = t_reg[axis_reg][31] ? {1'b0, scaled_q} : -{1'b0, scaled_q};
    assign force_div    = t_reg[axis_reg][31] ? {1'b0, div_q} : -{1'b0, div_q};

    assign div_req.start = (state_reg == S_FWB) && limited;
    assign div_req.numer = prod_reg[DIV_NUM_W-1:0];
    assign div_req.denom = largest_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DMUL;
                    axis_next  = '0;
                end
            end
            S_DMUL:
            begin
                state_next = S_DWB;
            end
            S_DWB:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_DFIX;
                    axis_next  = '0;
                end
                else
                begin
                    state_next = S_DMUL;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            S_DFIX:
            begin
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                state_next = S_PWB;
            end
            S_PWB:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_LARGE;
                    axis_next  = '0;
                end
                else
                begin
                    state_next = S_PMUL;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            S_LARGE:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_FMUL;
                    axis_next  = '0;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            S_FMUL:
            begin
                state_next = S_FWB;
            end
            S_FWB:
            begin
                if (limited)
                begin
                    state_next = S_DIV;
                end
                else if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_FMUL;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (axis_reg == LAST_AXIS)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_FMUL;
                        axis_next  = axis_reg + 2'd1;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            kp_reg        <= KP_RESET;
            kd_reg        <= KD_RESET;
            tmax_reg      <= TMAX_RESET;
            tmin_reg      <= TMIN_RESET;
            for (int i = 0; i < AXES; i++)
            begin
                prev_err_reg[i] <= '0;
                prev_d_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KP:   kp_reg   <= cfg_data;
                    REG_KD:   kd_reg   <= cfg_data;
                    REG_TMAX: tmax_reg <= cfg_data;
                    REG_TMIN: tmin_reg <= cfg_data;
                    default:  kp_reg   <= kp_reg;
                endcase
            end
            if (state_reg == S_DFIX)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    prev_d_reg[i] <= d_used[i];
                    if (all_nonzero)
                    begin
                        prev_err_reg[i] <= err_reg[i];
                    end
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    err_reg[0] <= {desired_angle_0[ANGLE_W-1], desired_angle_0}
                                - {measured_angle_0[ANGLE_W-1], measured_angle_0};
                    err_reg[1] <= {desired_angle_1[ANGLE_W-1], desired_angle_1}
                                - {measured_angle_1[ANGLE_W-1], measured_angle_1};
                    err_reg[2] <= {desired_angle_2[ANGLE_W-1], desired_angle_2}
                                - {measured_angle_2[ANGLE_W-1], measured_angle_2};
                    largest_reg <= '0;
                end
            end
            S_DMUL, S_PMUL, S_FMUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            S_DWB:
            begin
                d_reg[axis_reg] <= d_sat;
            end
            S_DFIX:
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    d_reg[i] <= d_used[i];
                end
            end
            S_PWB:
            begin
                t_reg[axis_reg] <= t_clamp;
            end
            S_LARGE:
            begin
                mag_reg[axis_reg] <= mag;
                if (mag > largest_reg)
                begin
                    largest_reg <= mag;
                end
            end
            S_FWB:
            begin
                if (!limited)
                begin
                    force_reg[axis_reg] <= force_scaled;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    force_reg[axis_reg] <= force_div;
                end
            end
            default:
            begin
                largest_reg <= largest_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                out_force_reg[i] <= force_reg[i];
            end
            out_limited_reg <= limited;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign force_command_0 = out_force_reg[0];
    assign force_command_1 = out_force_reg[1];
    assign force_command_2 = out_force_reg[2];
    assign torque_limited  = out_limited_reg;

endmodule

// ===== tb/three_axis_pd_torque_limiter_test.sv =====
// Self-checking testbench for the three-axis PD torque limiter with a cycle-free predictor.
`timescale 1ns / 1ps

module three_axis_pd_torque_limiter_test;
    import pdtl_pkg::*;

    typedef struct packed {
        logic [AXES-1:0][ANGLE_W-1:0] desired;
        logic [AXES-1:0][ANGLE_W-1:0] measured;
    } angle_tick_t;

    typedef struct packed {
        logic [AXES-1:0][FORCE_W-1:0] command;
        logic                         limited;
    } force_result_t;

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_value;
        angle_tick_t          angles;
        logic                 has_known;
        force_result_t        known;
    } directed_row_t;

    localparam logic signed [ANGLE_W-1:0] ANG_MAX = 4194303;
    localparam logic signed [ANGLE_W-1:0] ANG_MIN = -4194304;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] LIMIT_TORQUE = 64'sd1966080;
    localparam logic signed [63:0] FULL_FORCE = 64'sd300000;
    localparam logic signed [63:0] FORCE_PER_UNIT = 64'sd10000;
    localparam logic signed [63:0] Q16_ONE = 64'sd65536;

    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int WALK_STEP = 16384;
    localparam int ERR_SPAN = 131072;
    localparam int SEND_FLOW_FROM = 500;
    localparam int SEND_FLOW_TO = 700;
    localparam int RECV_FLOW_FROM = 600;
    localparam int RECV_FLOW_TO = 800;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_LIMIT = 10;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [ANGLE_W-1:0] desired_angle_0;
    logic signed [ANGLE_W-1:0] desired_angle_1;
    logic signed [ANGLE_W-1:0] desired_angle_2;
    logic signed [ANGLE_W-1:0] measured_angle_0;
    logic signed [ANGLE_W-1:0] measured_angle_1;
    logic signed [ANGLE_W-1:0] measured_angle_2;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [FORCE_W-1:0] force_command_0;
    logic signed [FORCE_W-1:0] force_command_1;
    logic signed [FORCE_W-1:0] force_command_2;
    logic                      torque_limited;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    // Predictor copy of the gains, clamp bounds and history.
    logic [CFG_W-1:0]         gain_p;
    logic [CFG_W-1:0]         gain_d;
    logic signed [CFG_W-1:0]  torque_hi;
    logic signed [CFG_W-1:0]  torque_lo;
    logic signed [ERR_W-1:0]  last_error [AXES];
    logic signed [31:0]       last_deriv [AXES];

    force_result_t pending_forces[$];
    directed_row_t stimulus_table[$];
    int            offered;
    int            received;
    int            mismatches;

    three_axis_pd_torque_limiter i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .desired_angle_0  (desired_angle_0),
        .desired_angle_1  (desired_angle_1),
        .desired_angle_2  (desired_angle_2),
        .measured_angle_0 (measured_angle_0),
        .measured_angle_1 (measured_angle_1),
        .measured_angle_2 (measured_angle_2),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .force_command_0  (force_command_0),
        .force_command_1  (force_command_1),
        .force_command_2  (force_command_2),
        .torque_limited   (torque_limited),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // One control tick of the PD law: error, P and D terms, clamp, limit, force scaling.
    function automatic force_result_t pd_control_tick(input angle_tick_t a);
        logic signed [63:0] err [AXES];
        logic signed [63:0] d [AXES];
        logic signed [63:0] t [AXES];
        logic signed [63:0] largest;
        logic signed [63:0] mag;
        logic signed [63:0] f;
        logic               all_zero;
        logic               all_nonzero;
        logic               limited;
        force_result_t      r;
        largest = 0;
        all_zero = 1'b1;
        all_nonzero = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            err[i] = $signed(a.desired[i]) - $signed(a.measured[i]);
            d[i] = ((err[i] - last_error[i]) * $signed({1'b0, gain_d})) >>> 20;
            if (d[i] > S32_MAX)
                d[i] = S32_MAX;
            if (d[i] < S32_MIN)
                d[i] = S32_MIN;
            if (d[i] != 0)
                all_zero = 1'b0;
        end
        // With no derivative on any axis, the previous derivative terms carry over.
        if (all_zero)
            for (int i = 0; i < AXES; i++)
                d[i] = last_deriv[i];
        for (int i = 0; i < AXES; i++) begin
            last_deriv[i] = d[i][31:0];
            if (d[i] == 0)
                all_nonzero = 1'b0;
            t[i] = ((err[i] * $signed({1'b0, gain_p})) >>> 20) + d[i];
            if (t[i] > torque_hi)
                t[i] = torque_hi;
            if (t[i] < torque_lo)
                t[i] = torque_lo;
            mag = (t[i] < 0) ? -t[i] : t[i];
            if (mag > largest)
                largest = mag;
        end
        if (all_nonzero)
            for (int i = 0; i < AXES; i++)
                last_error[i] = err[i][ERR_W-1:0];
        limited = largest > LIMIT_TORQUE;
        for (int i = 0; i < AXES; i++) begin
            if (limited)
                f = -((t[i] * FULL_FORCE) / largest);
            else
                f = -((t[i] * FORCE_PER_UNIT) / Q16_ONE);
            r.command[i] = f[FORCE_W-1:0];
        end
        r.limited = limited;
        return r;
    endfunction

    function automatic directed_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_W-1:0] val);
        directed_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic directed_row_t tick_row(
        input logic signed [ANGLE_W-1:0] d0, input logic signed [ANGLE_W-1:0] d1,
        input logic signed [ANGLE_W-1:0] d2, input logic signed [ANGLE_W-1:0] m0,
        input logic signed [ANGLE_W-1:0] m1, input logic signed [ANGLE_W-1:0] m2);
        directed_row_t row;
        row = '0;
        row.angles.desired[0] = d0;
        row.angles.desired[1] = d1;
        row.angles.desired[2] = d2;
        row.angles.measured[0] = m0;
        row.angles.measured[1] = m1;
        row.angles.measured[2] = m2;
        return row;
    endfunction

    function automatic directed_row_t known_row(
        input logic signed [ANGLE_W-1:0] d0, input logic signed [ANGLE_W-1:0] d1,
        input logic signed [ANGLE_W-1:0] d2, input logic signed [ANGLE_W-1:0] m0,
        input logic signed [ANGLE_W-1:0] m1, input logic signed [ANGLE_W-1:0] m2,
        input logic signed [FORCE_W-1:0] f0, input logic signed [FORCE_W-1:0] f1,
        input logic signed [FORCE_W-1:0] f2, input logic lim);
        directed_row_t row;
        row = tick_row(d0, d1, d2, m0, m1, m2);
        row.has_known = 1'b1;
        row.known.command[0] = f0;
        row.known.command[1] = f1;
        row.known.command[2] = f2;
        row.known.limited = lim;
        return row;
    endfunction

    // Registers are only written with no transaction in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_forces.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KP:   gain_p = val;
            REG_KD:   gain_d = val;
            REG_TMAX: torque_hi = val;
            REG_TMIN: torque_lo = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_tick(input angle_tick_t a, input logic has_known,
                             input force_result_t known);
        force_result_t predicted;
        while ((offered < SEND_FLOW_FROM || offered >= SEND_FLOW_TO)
               && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        desired_angle_0 <= a.desired[0];
        desired_angle_1 <= a.desired[1];
        desired_angle_2 <= a.desired[2];
        measured_angle_0 <= a.measured[0];
        measured_angle_1 <= a.measured[1];
        measured_angle_2 <= a.measured[2];
        do
            @(posedge clk);
        while (!in_ready);
        offered++;
        predicted = pd_control_tick(a);
        pending_forces.push_back(has_known ? known : predicted);
    endtask

    task automatic report_mismatch(input string what, input force_result_t want,
                                   input force_result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s: expected %0d %0d %0d limited %0d, got %0d %0d %0d limited %0d",
                     what, $signed(want.command[0]), $signed(want.command[1]),
                     $signed(want.command[2]), want.limited, $signed(got.command[0]),
                     $signed(got.command[1]), $signed(got.command[2]), got.limited);
    endtask

    initial begin
        angle_tick_t   walk;
        logic [CFG_W-1:0] kp_val;
        logic [CFG_W-1:0] kd_val;
        logic [CFG_W-1:0] hi_val;
        logic [CFG_W-1:0] lo_val;
        int            pick;
        int            hold_axis;
        int            step;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        desired_angle_0 = '0;
        desired_angle_1 = '0;
        desired_angle_2 = '0;
        measured_angle_0 = '0;
        measured_angle_1 = '0;
        measured_angle_2 = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gain_p = KP_RESET;
        gain_d = KD_RESET;
        torque_hi = TMAX_RESET;
        torque_lo = TMIN_RESET;
        for (int i = 0; i < AXES; i++) begin
            last_error[i] = '0;
            last_deriv[i] = '0;
        end
        offered = 0;
        received = 0;
        mismatches = 0;
        walk = '0;

        // Reset gains: full-scale errors end up on the 2.0 clamp.
        stimulus_table.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        stimulus_table.push_back(known_row(ANG_MAX, ANG_MAX, ANG_MAX, ANG_MIN, ANG_MIN,
                                           ANG_MIN, -20000, -20000, -20000, 1'b0));
        stimulus_table.push_back(known_row(ANG_MIN, ANG_MIN, ANG_MIN, ANG_MAX, ANG_MAX,
                                           ANG_MAX, 20000, 20000, 20000, 1'b0));
        stimulus_table.push_back(tick_row(ANG_MIN, ANG_MIN, ANG_MIN, ANG_MAX, ANG_MAX,
                                          ANG_MAX));
        stimulus_table.push_back(tick_row(1, 0, -1, 0, 0, 0));
        stimulus_table.push_back(tick_row(12345, -54321, 777, -3, 99, ANG_MAX));
        // Extreme gains and bounds: every axis saturates and the limiter scales.
        stimulus_table.push_back(reg_row(REG_KP, 32'hFFFF_FFFF));
        stimulus_table.push_back(reg_row(REG_KD, 32'hFFFF_FFFF));
        stimulus_table.push_back(reg_row(REG_TMAX, 32'h7FFF_FFFF));
        stimulus_table.push_back(reg_row(REG_TMIN, 32'h8000_0000));
        stimulus_table.push_back(known_row(ANG_MAX, ANG_MAX, ANG_MAX, ANG_MIN, ANG_MIN,
                                           ANG_MIN, -300000, -300000, -300000, 1'b1));
        stimulus_table.push_back(known_row(ANG_MIN, ANG_MIN, ANG_MIN, ANG_MAX, ANG_MAX,
                                           ANG_MAX, 300000, 300000, 300000, 1'b1));
        stimulus_table.push_back(tick_row(ANG_MAX, 0, ANG_MIN, 0, 0, 0));
        stimulus_table.push_back(tick_row(0, 0, 0, 0, 0, 0));
        // Clamp sits exactly at 30.0, so no scaling; no derivative gain at all.
        stimulus_table.push_back(reg_row(REG_KD, 32'd0));
        stimulus_table.push_back(reg_row(REG_TMAX, 32'd1966080));
        stimulus_table.push_back(reg_row(REG_TMIN, -32'd1966080));
        stimulus_table.push_back(known_row(ANG_MAX, ANG_MAX, ANG_MAX, ANG_MIN, ANG_MIN,
                                           ANG_MIN, -300000, -300000, -300000, 1'b0));
        stimulus_table.push_back(tick_row(ANG_MAX, ANG_MAX, ANG_MAX, ANG_MIN, ANG_MIN,
                                          ANG_MIN));
        // Crossed bounds: the lower bound is applied last and wins.
        stimulus_table.push_back(reg_row(REG_KP, KP_RESET));
        stimulus_table.push_back(reg_row(REG_KD, KD_RESET));
        stimulus_table.push_back(reg_row(REG_TMAX, -32'd65536));
        stimulus_table.push_back(reg_row(REG_TMIN, 32'd65536));
        stimulus_table.push_back(known_row(0, 0, 0, 0, 0, 0, -10000, -10000, -10000, 1'b0));
        stimulus_table.push_back(tick_row(-2000000, 3000000, 5, 1000000, -7, 4000000));
        stimulus_table.push_back(reg_row(REG_TMAX, TMAX_RESET));
        stimulus_table.push_back(reg_row(REG_TMIN, TMIN_RESET));
        stimulus_table.push_back(tick_row(1000, 2000, 3000, -1000, 0, 5000));
        stimulus_table.push_back(tick_row(1000, 2000, 3000, -1000, 0, 5000));
        stimulus_table.push_back(tick_row(ANG_MAX, ANG_MIN, 0, ANG_MAX, ANG_MIN, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stimulus_table[k]) begin
            if (stimulus_table[k].is_write)
                write_reg(stimulus_table[k].reg_index, stimulus_table[k].reg_value);
            else
                send_tick(stimulus_table[k].angles, stimulus_table[k].has_known,
                          stimulus_table[k].known);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    kp_val = KP_RESET;
                    kd_val = KD_RESET;
                    hi_val = TMAX_RESET;
                    lo_val = TMIN_RESET;
                end
                1: begin
                    kp_val = 32'hFFFF_FFFF;
                    kd_val = 32'hFFFF_FFFF;
                    hi_val = 32'h7FFF_FFFF;
                    lo_val = 32'h8000_0000;
                end
                2: begin
                    kp_val = '0;
                    kd_val = $urandom_range(1 << 16, 1 << 24);
                    hi_val = 32'h7FFF_FFFF;
                    lo_val = 32'h8000_0000;
                end
                PHASES - 1: begin
                    kp_val = $urandom;
                    kd_val = $urandom;
                    hi_val = $urandom;
                    lo_val = $urandom;
                end
                default: begin
                    kp_val = $urandom_range(0, 1 << 24);
                    kd_val = (phase == 3) ? '0 : $urandom_range(0, 1 << 22);
                    hi_val = $urandom_range(0, 5242880);
                    if ($urandom_range(5) == 0)
                        lo_val = hi_val + $urandom_range(0, 1 << 20);
                    else if ($urandom_range(1) == 0)
                        lo_val = -hi_val;
                    else
                        lo_val = -$urandom_range(0, 5242880);
                end
            endcase
            write_reg(REG_KP, kp_val);
            write_reg(REG_KD, kd_val);
            write_reg(REG_TMAX, hi_val);
            write_reg(REG_TMIN, lo_val);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    // Same tick again: the angles repeat those of the previous tick.
                end else if (pick < 25) begin
                    for (int i = 0; i < AXES; i++) begin
                        walk.desired[i] = ANGLE_W'($urandom);
                        walk.measured[i] = ANGLE_W'($urandom);
                    end
                end else begin
                    // A slowly moving target tracked within a fraction of a radian.
                    hold_axis = (pick < 35) ? $urandom_range(AXES - 1) : AXES;
                    for (int i = 0; i < AXES; i++) begin
                        if (i != hold_axis) begin
                            step = int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP;
                            walk.desired[i] = walk.desired[i] + step[ANGLE_W-1:0];
                            step = int'($urandom_range(0, 2 * ERR_SPAN)) - ERR_SPAN;
                            walk.measured[i] = walk.desired[i] - step[ANGLE_W-1:0];
                        end
                    end
                end
                send_tick(walk, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("three_axis_pd_torque_limiter: match");
        else
            $display("three_axis_pd_torque_limiter: mismatch");
        $finish;
    end

    initial begin
        force_result_t got;
        force_result_t want;
        int            hold_left;
        logic          held;
        logic          bad;
        hold_left = 0;
        held = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.command[0] = force_command_0;
                got.command[1] = force_command_1;
                got.command[2] = force_command_2;
                got.limited = torque_limited;
                if (pending_forces.size() == 0) begin
                    report_mismatch("unexpected transaction", '0, got);
                end else begin
                    want = pending_forces.pop_front();
                    bad = (got.limited !== want.limited);
                    for (int i = 0; i < AXES; i++)
                        if (got.command[i] !== want.command[i])
                            bad = 1'b1;
                    if (bad)
                        report_mismatch("force command mismatch", want, got);
                end
                received++;
            end
            // One long back-pressure stretch so the block fills and stalls its input.
            if (!held && received == HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (received >= RECV_FLOW_FROM && received < RECV_FLOW_TO) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("three_axis_pd_torque_limiter: mismatch");
        $finish;
    end

endmodule

// ===== three_axis_pd_torque_limiter.f =====
sv/pdtl_pkg.sv
sv/pdtl_div.sv
sv/three_axis_pd_torque_limiter.sv
tb/three_axis_pd_torque_limiter_test.sv
